FILE: sv/svbe_pkg.sv
// ----------------------------------------------------------------------------
// svbe_pkg
// Shared types, constants and the base64 alphabet for the varint base64
// encoder.
// ----------------------------------------------------------------------------
package svbe_pkg;

  // Default sample width and register layout
  localparam int              SAMPLE_WIDTH_DEF = 32;
  localparam int              OFFSET_W         = 16;
  localparam logic [15:0]     OFFSET_RST       = 16'd100;
  localparam int              CHAR_W           = 7;
  localparam int              GROUP_BITS       = 7;
  localparam int              CHARS_PER_QUAD   = 4;

  // Special characters
  localparam logic [6:0]      PAD_CHAR         = 7'd61;
  localparam logic [6:0]      NUL_CHAR         = 7'd0;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GROUP,
    ST_EMIT,
    ST_FLUSH,
    ST_TERM
  } svbe_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // take the input transaction
    logic group;   // form one varint byte and push it into the packer
    logic flush;   // load padded flush characters, clear held bytes
    logic emit;    // move the next character into the output register
    logic term;    // move the NUL terminator into the output register
  } svbe_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic gt_offset;   // incoming sample is above the offset
    logic in_last;     // incoming transaction is marked last
    logic last;        // stored item is marked last
    logic rem_more;    // more groups follow the one being formed
    logic rem_nz;      // remainder still holds groups
    logic pend_full;   // two bytes held
    logic pend_empty;  // no bytes held
    logic slot_free;   // output register can take a character
    logic emit_final;  // character being emitted is the last of its quad
  } svbe_stat_t;

  // Base64 alphabet: A-Z a-z 0-9 + /
  function automatic logic [6:0] b64_char(input logic [5:0] idx);
    logic [6:0] code;
    if (idx < 6'd26) begin
      code = 7'd65 + {1'b0, idx};
    end else if (idx < 6'd52) begin
      code = 7'd71 + {1'b0, idx};
    end else if (idx < 6'd62) begin
      code = {1'b0, idx} - 7'd4;
    end else if (idx == 6'd62) begin
      code = 7'd43;
    end else begin
      code = 7'd47;
    end
    return code;
  endfunction

endpackage

FILE: sv/svbe_in_if.sv
// ----------------------------------------------------------------------------
// svbe_in_if
// Input channel: one pulse interval per transaction, valid/ready handshake.
// ----------------------------------------------------------------------------
interface svbe_in_if #(
  parameter int SAMPLE_WIDTH = 32
);
  logic                    valid;
  logic                    ready;
  logic [SAMPLE_WIDTH-1:0] sample;
  logic                    last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

FILE: sv/svbe_out_if.sv
// ----------------------------------------------------------------------------
// svbe_out_if
// Result channel: one ASCII character per transaction, valid/ready handshake.
// ----------------------------------------------------------------------------
interface svbe_out_if;
  import svbe_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

FILE: sv/sample_varint_base64_encoder_top.sv
// ----------------------------------------------------------------------------
// sample_varint_base64_encoder_top
// Pulse interval to LEB128 varint bytes to base64 text encoder.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch takes one pulse interval per transaction (sample, last_sample).
//   Intervals at or below the offset register are dropped; kept ones have
//   the offset subtracted and are cut into 7-bit varint bytes, which are
//   packed three bytes to four base64 characters on out_ch. A transaction
//   marked last flushes held bytes with '=' padding and then sends a NUL
//   character with last_char set. cfg_we/cfg_wdata write the 16-bit offset
//   (reset value 100); the user must do so only while idle, the block does not enforce it.
// Sequence:
//   One item at a time. The sequencer accepts the item, then forms each
//   varint byte and emits each character in turn, and on a last item flushes
//   held bytes and sends the terminator. The third held byte fills the quad
//   buffer; its first character then moves into the output register once free.
// Reset and stall:
//   Synchronous active-low reset clears held bytes and restores the offset.
//   A stalled receiver holds the output register; the sequencer waits.
// ----------------------------------------------------------------------------
module sample_varint_base64_encoder_top #(
  parameter int SAMPLE_WIDTH = svbe_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  svbe_in_if.sink                       in_ch,
  svbe_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [svbe_pkg::OFFSET_W-1:0] cfg_wdata
);
  import svbe_pkg::*;

  svbe_cmd_t  cmd;
  svbe_stat_t stat;

  // Sequencer
  svbe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath
  svbe_dp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_sample      (in_ch.sample),
    .in_last_sample (in_ch.last_sample),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_char_code  (out_ch.char_code),
    .out_last_char  (out_ch.last_char),
    .cmd            (cmd),
    .stat           (stat)
  );

  // A character is only loaded when the output register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit || cmd.term) |-> stat.slot_free)
    else $error("character loaded into a busy output register");

  // The flagged character is always the NUL terminator
  a_last_is_nul: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.last_char) |-> (out_ch.char_code == NUL_CHAR))
    else $error("last character is not NUL");

  // No bytes are held after the terminator
  a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.term |=> stat.pend_empty)
    else $error("held bytes remain after terminator");

  // Input is taken only when no character work is pending
  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !(cmd.emit || cmd.group || cmd.flush || cmd.term))
    else $error("input taken during character work");

endmodule

FILE: sv/svbe_ctrl.sv
// ----------------------------------------------------------------------------
// svbe_ctrl
// Sequencer: steps one item through varint grouping, base64 emission,
// flush and terminator.
// ----------------------------------------------------------------------------
module svbe_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  svbe_pkg::svbe_stat_t stat,
  output svbe_pkg::svbe_cmd_t  cmd
);
  import svbe_pkg::*;

  svbe_state_t state_r, state_nxt;
  logic        from_flush_r, from_flush_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      from_flush_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      from_flush_r <= from_flush_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt      = state_r;
    from_flush_nxt = from_flush_r;
    in_ready       = 1'b0;
    cmd            = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (stat.gt_offset) begin
            state_nxt = ST_GROUP;
          end else if (stat.in_last) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_GROUP: begin
        cmd.group = 1'b1;
        if (stat.pend_full) begin
          state_nxt      = ST_EMIT;
          from_flush_nxt = 1'b0;
        end else if (stat.rem_more) begin
          state_nxt = ST_GROUP;
        end else if (stat.last) begin
          state_nxt = ST_FLUSH;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        cmd.flush = 1'b1;
        if (stat.pend_empty) begin
          state_nxt = ST_TERM;
        end else begin
          state_nxt      = ST_EMIT;
          from_flush_nxt = 1'b1;
        end
      end
      ST_EMIT: begin
        if (stat.slot_free) begin
          cmd.emit = 1'b1;
          if (stat.emit_final) begin
            if (from_flush_r) begin
              state_nxt = ST_TERM;
            end else if (stat.rem_nz) begin
              state_nxt = ST_GROUP;
            end else if (stat.last) begin
              state_nxt = ST_FLUSH;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      ST_TERM: begin
        if (stat.slot_free) begin
          cmd.term  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/svbe_dp.sv
// ----------------------------------------------------------------------------
// svbe_dp
// Datapath: offset register, varint remainder, base64 byte holder, quad
// character buffer and output register.
// ----------------------------------------------------------------------------
module svbe_dp #(
  parameter int SAMPLE_WIDTH = svbe_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [svbe_pkg::OFFSET_W-1:0] cfg_wdata,
  input  logic [SAMPLE_WIDTH-1:0]       in_sample,
  input  logic                          in_last_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [svbe_pkg::CHAR_W-1:0]   out_char_code,
  output logic                          out_last_char,
  input  svbe_pkg::svbe_cmd_t           cmd,
  output svbe_pkg::svbe_stat_t          stat
);
  import svbe_pkg::*;

  localparam int CMP_W = (SAMPLE_WIDTH > OFFSET_W) ? SAMPLE_WIDTH : OFFSET_W;

  logic [OFFSET_W-1:0]     offset_r;
  logic [SAMPLE_WIDTH-1:0] rem_r;
  logic                    last_r;
  logic [15:0]             pend_r;
  logic [1:0]              cnt_r;
  logic [CHAR_W-1:0]       chars_r [CHARS_PER_QUAD];
  logic [1:0]              idx_r;
  logic                    out_valid_r;
  logic [CHAR_W-1:0]       out_code_r;
  logic                    out_last_r;

  logic [CMP_W-1:0]        s_ext, o_ext, diff;
  logic                    rem_more;
  logic [7:0]              vbyte;
  logic [7:0]              b0, b1;
  logic                    slot_free;

  // Offset compare and subtract
  assign s_ext = CMP_W'(in_sample);
  assign o_ext = CMP_W'(offset_r);
  assign diff  = s_ext - o_ext;

  // Next varint byte
  assign rem_more = |rem_r[SAMPLE_WIDTH-1:GROUP_BITS];
  assign vbyte    = {rem_more, rem_r[GROUP_BITS-1:0]};
  assign b0       = pend_r[7:0];
  assign b1       = pend_r[15:8];

  assign slot_free = !out_valid_r || out_ready;

  // Status to the controller
  always_comb begin
    stat.gt_offset  = s_ext > o_ext;
    stat.in_last    = in_last_sample;
    stat.last       = last_r;
    stat.rem_more   = rem_more;
    stat.rem_nz     = |rem_r;
    stat.pend_full  = cnt_r == 2'd2;
    stat.pend_empty = cnt_r == 2'd0;
    stat.slot_free  = slot_free;
    stat.emit_final = idx_r == 2'(CHARS_PER_QUAD - 1);
  end

  // Offset register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= OFFSET_RST;
    end else if (cfg_we) begin
      offset_r <= cfg_wdata;
    end
  end

  // Item registers and varint remainder
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_r  <= diff[SAMPLE_WIDTH-1:0];
      last_r <= in_last_sample;
    end else if (cmd.group) begin
      rem_r  <= rem_r >> GROUP_BITS;
    end
  end

  // Held bytes count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (cmd.group) begin
      cnt_r <= (cnt_r == 2'd2) ? 2'd0 : cnt_r + 2'd1;
    end else if (cmd.flush) begin
      cnt_r <= 2'd0;
    end
  end

  // Held bytes and quad character buffer
  always_ff @(posedge clk) begin
    if (cmd.group) begin
      case (cnt_r)
        2'd0: pend_r[7:0]  <= vbyte;
        2'd1: pend_r[15:8] <= vbyte;
        default: begin
          chars_r[0] <= b64_char(b0[7:2]);
          chars_r[1] <= b64_char({b0[1:0], b1[7:4]});
          chars_r[2] <= b64_char({b1[3:0], vbyte[7:6]});
          chars_r[3] <= b64_char(vbyte[5:0]);
        end
      endcase
    end else if (cmd.flush) begin
      chars_r[0] <= b64_char(b0[7:2]);
      chars_r[3] <= PAD_CHAR;
      if (cnt_r == 2'd1) begin
        chars_r[1] <= b64_char({b0[1:0], 4'd0});
        chars_r[2] <= PAD_CHAR;
      end else begin
        chars_r[1] <= b64_char({b0[1:0], b1[7:4]});
        chars_r[2] <= b64_char({b1[3:0], 2'd0});
      end
    end else if (cmd.emit) begin
      for (int i = 0; i < CHARS_PER_QUAD - 1; i++) begin
        chars_r[i] <= chars_r[i+1];
      end
    end
  end

  // Character position within the quad
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else if (cmd.group || cmd.flush) begin
      idx_r <= 2'd0;
    end else if (cmd.emit) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit || cmd.term) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_code_r <= chars_r[0];
      out_last_r <= 1'b0;
    end else if (cmd.term) begin
      out_code_r <= NUL_CHAR;
      out_last_r <= 1'b1;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_code_r;
  assign out_last_char = out_last_r;

endmodule

FILE: test/svbe_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// svbe_tb_pkg
// Scoreboard for the varint base64 encoder: it tracks the offset register and
// the held bytes, turns each accepted interval into the characters the block
// owes, and checks every character that leaves the block.
// ----------------------------------------------------------------------------
package svbe_tb_pkg;
  import svbe_pkg::*;

  // One character of encoded text
  typedef struct {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  class b64_text_scoreboard;
    logic [OFFSET_W-1:0] drop_level;
    logic [15:0]         held;
    int unsigned         held_n;
    text_char_t          chars_due[$];
    int unsigned         mismatches;
    string               alphabet =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    function new();
      drop_level = OFFSET_RST;
      held       = '0;
      held_n     = 0;
      mismatches = 0;
    endfunction

    function void set_offset(input logic [OFFSET_W-1:0] value);
      drop_level = value;
    endfunction

    function int unsigned chars_outstanding();
      return chars_due.size();
    endfunction

    function void queue_char(input logic [CHAR_W-1:0] code, input logic is_last);
      text_char_t c;
      c.code = code;
      c.last = is_last;
      chars_due.push_back(c);
    endfunction

    function void queue_b64(input logic [5:0] idx);
      byte ch;
      ch = alphabet[idx];
      queue_char(ch[6:0], 1'b0);
    endfunction

    // Packer: hold two bytes, the third completes a quad of characters
    function void push_varint_byte(input logic [7:0] b);
      if (held_n < 2) begin
        if (held_n == 0) begin
          held = {8'h00, b};
        end else begin
          held[15:8] = b;
        end
        held_n++;
      end else begin
        queue_b64(held[7:2]);
        queue_b64({held[1:0], held[15:12]});
        queue_b64({held[11:8], b[7:6]});
        queue_b64(b[5:0]);
        held   = '0;
        held_n = 0;
      end
    endfunction

    // End of buffer: padded partial quad, then the NUL terminator
    function void flush_held();
      if (held_n == 1) begin
        queue_b64(held[7:2]);
        queue_b64({held[1:0], 4'b0000});
        queue_char(PAD_CHAR, 1'b0);
        queue_char(PAD_CHAR, 1'b0);
      end else if (held_n == 2) begin
        queue_b64(held[7:2]);
        queue_b64({held[1:0], held[15:12]});
        queue_b64({held[11:8], 2'b00});
        queue_char(PAD_CHAR, 1'b0);
      end
      held   = '0;
      held_n = 0;
      queue_char(NUL_CHAR, 1'b1);
    endfunction

    // Accepted input transaction: cut the interval into LEB128 bytes
    function void note_sample(input logic [31:0] sample, input logic is_last);
      logic [31:0] rest;
      logic [6:0]  grp;
      if (sample > {16'h0000, drop_level}) begin
        rest = sample - {16'h0000, drop_level};
        while (rest != 0) begin
          grp  = rest[6:0];
          rest = rest >> GROUP_BITS;
          push_varint_byte({rest != 0, grp});
        end
      end
      if (is_last) begin
        flush_held();
      end
    endfunction

    task report_mismatch(input string msg);
      $display("%0t ns  mismatch: %s", $time, msg);
      mismatches++;
    endtask

    // Accepted output transaction: compare against the oldest owed character
    task check_char(input logic [CHAR_W-1:0] code, input logic is_last);
      text_char_t want;
      if (chars_due.size() == 0) begin
        report_mismatch($sformatf("unexpected char 0x%02h last=%0b", code, is_last));
        return;
      end
      want = chars_due.pop_front();
      if (code !== want.code) begin
        report_mismatch($sformatf("char_code 0x%02h, want 0x%02h", code, want.code));
      end
      if (is_last !== want.last) begin
        report_mismatch($sformatf("last_char %0b, want %0b on char 0x%02h",
                                  is_last, want.last, want.code));
      end
    endtask

    task check_drained();
      if (chars_due.size() != 0) begin
        report_mismatch($sformatf("%0d chars never arrived", chars_due.size()));
      end
    endtask
  endclass

endpackage

FILE: test/tb_sample_varint_base64_encoder_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sample_varint_base64_encoder_top
// Drives pulse intervals into the encoder under random gaps on both channels,
// a long receiver hold-off and several offset settings, and checks every
// character against a scoreboard that encodes the same intervals.
// ----------------------------------------------------------------------------
module tb_sample_varint_base64_encoder_top;
  import svbe_pkg::*;
  import svbe_tb_pkg::*;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_ITEMS   = 44;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [OFFSET_W-1:0] cfg_wdata;
  logic                idle_on;
  logic                hold_req;
  int                  cycle_count = 0;
  b64_text_scoreboard  book;

  svbe_in_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH_DEF)) in_ch ();
  svbe_out_if out_ch ();

  sample_varint_base64_encoder_top #(.SAMPLE_WIDTH(SAMPLE_WIDTH_DEF)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Cycle count and output monitor
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      book.check_char(out_ch.char_code, out_ch.last_char);
    end
  end

  // Watchdog
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb_sample_varint_base64_encoder_top: FAIL");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin : sink_driver
    int hold_left;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= !(idle_on && $urandom_range(99) < 12);
      end
    end
  end

  // Offer one interval; starts and returns at a falling edge
  task automatic send_sample(input logic [31:0] sample, input logic is_last);
    while (idle_on && $urandom_range(99) < 12) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.sample      <= sample;
    in_ch.last_sample <= is_last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    book.note_sample(sample, is_last);
    @(negedge clk);
  endtask

  // Stop offering, wait for every owed char, then let the sequencer settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (book.chars_outstanding() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_offset(input logic [OFFSET_W-1:0] value);
    drain();
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    book.set_offset(value);
  endtask

  // Mostly kept intervals of short to full width, a few drops
  function automatic logic [31:0] pick_interval(input logic [OFFSET_W-1:0] ofs);
    logic [31:0] span;
    span = $urandom >> $urandom_range(31);
    case ($urandom_range(9))
      0:       return $urandom_range(ofs);
      1:       return $urandom;
      2, 3:    return ofs + 32'd1 + span;
      default: return ofs + 32'd1 + $urandom_range(400);
    endcase
  endfunction

  task automatic run_random(input int count);
    int k;
    for (k = 0; k < count; k++) begin
      send_sample(pick_interval(book.drop_level), $urandom_range(7) == 0);
    end
  endtask

  // Stimulus
  initial begin
    book              = new();
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.sample      = '0;
    in_ch.last_sample = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    idle_on           = 1'b1;
    hold_req          = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset offset: drops, byte counts one to five, flushes of 0/1/2 held
    send_sample(32'd0, 1'b0);
    send_sample(32'd100, 1'b0);
    send_sample(32'd101, 1'b0);
    send_sample(32'd50, 1'b1);
    send_sample(32'd7, 1'b1);
    send_sample(32'd228, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b1);
    send_sample(32'd228, 1'b1);
    send_sample(32'd100 + 32'd16384, 1'b0);
    send_sample(32'd100 + 32'd2097152, 1'b0);
    send_sample(32'h8000_0000, 1'b1);

    // Offset at zero
    write_offset(16'h0000);
    send_sample(32'd0, 1'b0);
    send_sample(32'd1, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'h0000_007F, 1'b1);

    // Offset at its top
    write_offset(16'hFFFF);
    send_sample(32'd65535, 1'b0);
    send_sample(32'd65536, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b1);
    send_sample(32'h5555_AAAA, 1'b0);
    send_sample(32'd0, 1'b1);

    // Random: small offset
    write_offset(16'($urandom_range(200)));
    run_random(PHASE_ITEMS);

    // Random: any offset, receiver holds off so the block backs up
    write_offset(16'($urandom_range(65535)));
    hold_req = 1'b1;
    run_random(PHASE_ITEMS);

    // Random: reset offset, no idling on either side
    write_offset(OFFSET_RST);
    idle_on = 1'b0;
    run_random(PHASE_ITEMS);
    send_sample(32'd0, 1'b1);

    drain();
    book.check_drained();
    if (book.mismatches == 0) begin
      $display("tb_sample_varint_base64_encoder_top: PASS");
    end else begin
      $display("tb_sample_varint_base64_encoder_top: FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/svbe_pkg.sv
sv/svbe_in_if.sv
sv/svbe_out_if.sv
sv/svbe_ctrl.sv
sv/svbe_dp.sv
sv/sample_varint_base64_encoder_top.sv
test/svbe_tb_pkg.sv
test/tb_sample_varint_base64_encoder_top.sv
